// ----- sv/aging_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// aging_priority_queue assertion macros
// Shorthand for the concurrent checks on the queue, clocked on clk and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AGING_PRIORITY_QUEUE_ASSERT_SVH
`define AGING_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define APQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Command, status and cell control types for the aging priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_TICK
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// ----- sv/apq_cell.sv -----
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted shift-register queue. Keeps, takes the new word,
// or takes a neighbour's entry depending on the broadcast operation.
// ----------------------------------------------------------------------------
module apq_cell
    import apq_pkg::*;
#(
    parameter int PRIORITY_WIDTH = 16,
    parameter int PAYLOAD_WIDTH  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cell_ctrl_t                       ctrl,
    input  logic signed [PRIORITY_WIDTH-1:0] new_prio,
    input  logic        [PAYLOAD_WIDTH-1:0]  new_payload,
    input  logic                             left_valid,
    input  logic signed [PRIORITY_WIDTH-1:0] left_prio,
    input  logic        [PAYLOAD_WIDTH-1:0]  left_payload,
    input  logic                             left_gt,
    input  logic                             right_valid,
    input  logic signed [PRIORITY_WIDTH-1:0] right_prio,
    input  logic        [PAYLOAD_WIDTH-1:0]  right_payload,
    output logic                             valid,
    output logic signed [PRIORITY_WIDTH-1:0] prio,
    output logic        [PAYLOAD_WIDTH-1:0]  payload,
    output logic                             gt
);

    localparam logic signed [PRIORITY_WIDTH-1:0] PRIO_MIN =
        {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};

    logic                             valid_reg, valid_next;
    logic signed [PRIORITY_WIDTH-1:0] prio_reg, prio_next;
    logic        [PAYLOAD_WIDTH-1:0]  payload_reg, payload_next;

    // new word goes behind every entry of equal or lower priority
    assign gt = !valid_reg || (prio_reg > new_prio);

    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        unique case (ctrl.op)
            OP_PUSH:
            begin
                if (gt)
                begin
                    if (!left_gt)
                    begin
                        valid_next   = 1'b1;
                        prio_next    = new_prio;
                        payload_next = new_payload;
                    end
                    else
                    begin
                        valid_next   = left_valid;
                        prio_next    = left_prio;
                        payload_next = left_payload;
                    end
                end
            end
            OP_POP:
            begin
                valid_next   = right_valid;
                prio_next    = right_prio;
                payload_next = right_payload;
            end
            OP_TICK:
            begin
                if (valid_reg && (prio_reg != PRIO_MIN))
                    prio_next = prio_reg - PRIORITY_WIDTH'(1);
            end
            OP_HOLD:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// ----- sv/aging_priority_queue.sv -----
// ----------------------------------------------------------------------------
// aging_priority_queue
// Sorted priority queue with aging, built as a chain of slot cells.
// Result strobed on done in the cycle after start is taken.
// Throughput: one command per cycle; every cell compares and shifts at once.
// busy is held low; the receiver cannot stall and needs none.
// Reset clears all valid bits and the entry count; slot data is not reset.
// ----------------------------------------------------------------------------
`include "aging_priority_queue_assert.svh"

module aging_priority_queue
    import apq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic signed [PRIORITY_WIDTH-1:0]      new_priority,
    input  logic        [PAYLOAD_WIDTH-1:0]       new_payload,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [PRIORITY_WIDTH-1:0]      out_priority,
    output logic        [PAYLOAD_WIDTH-1:0]       out_payload,
    output logic                                  is_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      entry_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0]           cell_valid;
    logic [QUEUE_DEPTH-1:0]           cell_gt;
    logic signed [PRIORITY_WIDTH-1:0] cell_prio    [QUEUE_DEPTH];
    logic        [PAYLOAD_WIDTH-1:0]  cell_payload [QUEUE_DEPTH];

    cell_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       empty;

    logic                             done_reg, done_next;
    status_t                          status_reg, status_next;
    logic signed [PRIORITY_WIDTH-1:0] oprio_reg, oprio_next;
    logic        [PAYLOAD_WIDTH-1:0]  opay_reg, opay_next;
    logic        [CNT_W-1:0]          count_reg, count_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = cell_valid[QUEUE_DEPTH-1];
    assign empty  = !cell_valid[0];

    always_comb
    begin
        ctrl.op     = OP_HOLD;
        done_next   = accept;
        status_next = ST_OK;
        oprio_next  = '0;
        opay_next   = '0;
        count_next  = count_reg;
        if (accept)
        begin
            unique case (command)
                CMD_PUSH:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.op    = OP_PUSH;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctrl.op    = OP_POP;
                        oprio_next = cell_prio[0];
                        opay_next  = cell_payload[0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_TICK:
                    ctrl.op = OP_TICK;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                             l_valid, r_valid, l_gt;
        logic signed [PRIORITY_WIDTH-1:0] l_prio, r_prio;
        logic        [PAYLOAD_WIDTH-1:0]  l_payload, r_payload;

        if (i == 0)
        begin : g_head
            assign l_valid   = 1'b0;
            assign l_prio    = '0;
            assign l_payload = '0;
            assign l_gt      = 1'b0;
        end
        else
        begin : g_mid
            assign l_valid   = cell_valid[i-1];
            assign l_prio    = cell_prio[i-1];
            assign l_payload = cell_payload[i-1];
            assign l_gt      = cell_gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_valid   = 1'b0;
            assign r_prio    = '0;
            assign r_payload = '0;
        end
        else
        begin : g_body
            assign r_valid   = cell_valid[i+1];
            assign r_prio    = cell_prio[i+1];
            assign r_payload = cell_payload[i+1];
        end

        apq_cell #(
            .PRIORITY_WIDTH (PRIORITY_WIDTH),
            .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_prio      (new_priority),
            .new_payload   (new_payload),
            .left_valid    (l_valid),
            .left_prio     (l_prio),
            .left_payload  (l_payload),
            .left_gt       (l_gt),
            .right_valid   (r_valid),
            .right_prio    (r_prio),
            .right_payload (r_payload),
            .valid         (cell_valid[i]),
            .prio          (cell_prio[i]),
            .payload       (cell_payload[i]),
            .gt            (cell_gt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            oprio_reg  <= '0;
            opay_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg   <= done_next;
            status_reg <= status_next;
            oprio_reg  <= oprio_next;
            opay_reg   <= opay_next;
            count_reg  <= count_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = oprio_reg;
    assign out_payload  = opay_reg;
    assign entry_count  = count_reg;
    assign is_empty     = (count_reg == '0);

    // occupied slots form an unbroken run from the head
    `APQ_ASSERT_SAME(a_valid_prefix, 1'b1,
        (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0, "valid bits not a prefix")
    `APQ_ASSERT_SAME(a_count_match, 1'b1,
        $countones(cell_valid) == int'(count_reg), "entry count off the valid bits")
    `APQ_ASSERT_NEXT(a_done_follows, accept, done, "no word strobed after start")
    `APQ_ASSERT_NEXT(a_no_spurious, !accept, !done, "word strobed without start")
    `APQ_ASSERT_SAME(a_empty_status, done && (status_reg == ST_EMPTY),
        (count_reg == '0) && (oprio_reg == '0) && (opay_reg == '0), "empty pop with data")

endmodule
